// ----- design/qcm_pkg.sv -----
// Shared types, constants and helper functions for the quad corner metrics unit.
// No dependencies.
package qcm_pkg;

    localparam int unsigned COORD_W = 18;
    localparam int unsigned EDGE_W  = 19;
    localparam int unsigned PROD_W  = 40;
    localparam int unsigned CORD_W  = 46;
    localparam int unsigned Z_W     = 33;
    localparam int unsigned STEPS   = 31;
    localparam int unsigned SQ_W    = 42;
    localparam int unsigned ROOT_W  = 21;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [EDGE_W-1:0]  edge_t;

    // Control word that travels with each pipeline stage
    typedef struct packed {
        logic valid;
        logic degen;
    } stage_ctl_t;

    // Angle step table, Q30 radians
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            default: v = 30'd1 << (5'd30 - idx);
        endcase
        return v;
    endfunction

endpackage

// ----- design/qcm_cordic.sv -----
// Pipelined atan2 unit: normalize, quadrant fold, then one CORDIC rotation per stage.
// Depends on qcm_pkg.
module qcm_cordic
    import qcm_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic signed [PROD_W:0]  y_in,
    input  logic signed [PROD_W:0]  x_in,
    output logic signed [Z_W-1:0]   z_out
);

    localparam int unsigned NS = STEPS + 1;

    logic signed [CORD_W-1:0] x_reg [NS];
    logic signed [CORD_W-1:0] y_reg [NS];
    logic signed [Z_W-1:0]    z_reg [NS];
    logic [5:0]               sh_reg;
    logic signed [PROD_W:0]   yi_reg;
    logic signed [PROD_W:0]   xi_reg;
    logic                     zero_reg;

    logic [PROD_W:0] mx;
    logic [PROD_W:0] my;
    logic [PROD_W:0] mm;
    logic [5:0]      sh;

    // Find normalizing shift from the larger magnitude (leading-one detect)
    always_comb
    begin
        mx = x_in[PROD_W] ? (~x_in + 1'b1) : x_in;
        my = y_in[PROD_W] ? (~y_in + 1'b1) : y_in;
        mm = (mx > my) ? mx : my;
        sh = 6'd0;
        for (int b = 0; b <= PROD_W; b++)
        begin
            if (mm[b])
            begin
                sh = (b >= 40) ? 6'd0 : 6'(40 - b);
            end
        end
    end

    // Register operands with their shift amount
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sh_reg   <= sh;
            yi_reg   <= y_in;
            xi_reg   <= x_in;
            zero_reg <= (x_in == '0) && (y_in == '0);
        end
    end

    // Shift and fold into the right half plane
    logic signed [CORD_W-1:0] xn;
    logic signed [CORD_W-1:0] yn;
    always_comb
    begin
        xn = CORD_W'(xi_reg) <<< sh_reg;
        yn = CORD_W'(yi_reg) <<< sh_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg)
            begin
                x_reg[0] <= '0;
                y_reg[0] <= '0;
                z_reg[0] <= '0;
            end
            else if (xn < 0 && yn >= 0)
            begin
                x_reg[0] <= yn;
                y_reg[0] <= -xn;
                z_reg[0] <= HALF_PI_Q30;
            end
            else if (xn < 0)
            begin
                x_reg[0] <= -yn;
                y_reg[0] <= xn;
                z_reg[0] <= -HALF_PI_Q30;
            end
            else
            begin
                x_reg[0] <= xn;
                y_reg[0] <= yn;
                z_reg[0] <= '0;
            end
        end
    end

    // Rotation stages; a zero vector holds z at 0
    logic zv_reg [NS];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            zv_reg[0] <= zero_reg;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                zv_reg[i+1] <= zv_reg[i];
                if (y_reg[i] > 0)
                begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + Z_W'(atan_q30(5'(i)));
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - Z_W'(atan_q30(5'(i)));
                end
            end
        end
    end

    assign z_out = zv_reg[STEPS] ? '0 : z_reg[STEPS];

endmodule

// ----- design/qcm_isqrt.sv -----
// Pipelined rounded integer square root, one result bit per stage.
// Depends on qcm_pkg.
module qcm_isqrt
    import qcm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [SQ_W-1:0]   val,
    output logic [ROOT_W:0]   root
);

    logic [SQ_W-1:0]   rem_reg  [ROOT_W+1];
    logic [ROOT_W:0]   r_reg    [ROOT_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= val;
            r_reg[0]   <= '0;
        end
    end

    // Restoring digit-by-digit square root, MSB first
    for (genvar k = 0; k < ROOT_W; k++)
    begin : g_bit
        localparam int unsigned B = ROOT_W - 1 - k;
        logic [SQ_W+1:0] trial;
        assign trial = ((SQ_W+2)'(r_reg[k]) << (B + 1)) + ((SQ_W+2)'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if ((SQ_W+2)'(rem_reg[k]) >= trial)
                begin
                    rem_reg[k+1] <= rem_reg[k] - SQ_W'(trial);
                    r_reg[k+1]   <= r_reg[k] | ((ROOT_W+1)'(1) << B);
                end
                else
                begin
                    rem_reg[k+1] <= rem_reg[k];
                    r_reg[k+1]   <= r_reg[k];
                end
            end
        end
    end

    // Round up when remainder exceeds root
    assign root = r_reg[ROOT_W] +
        ((ROOT_W+1)'((SQ_W+1)'(rem_reg[ROOT_W]) > (SQ_W+1)'(r_reg[ROOT_W])));

endmodule

// ----- design/quad_corner_metrics_unit.sv -----
// Quad corner metrics unit: side lanes, corner-angle lanes, orientation lane, merge stages.
// Depends on qcm_pkg, qcm_cordic, qcm_isqrt.
//
// Usage:
//   Input channel in_valid/in_ready carries one word of four corners
//   (18-bit signed x/y each). Output channel out_valid/out_ready carries
//   mean_side, squareness, orientation and degenerate for that word.
//   Four side lanes (square root) and four corner lanes (atan2) plus one
//   orientation atan2 run side by side; merge stages fold their results.
//   Throughput: one word per cycle while the receiver does not stall. A word
//   passes the input and product registers (2), the CORDIC
//   normalize and fold stages (2) and its 31 rotations, merge A (1), the
//   squareness scale in merge B1 and B2 (2) and the output register.
//   The whole pipeline advances only when the output register is empty or
//   being drained, so a stalled receiver freezes every stage and in_ready
//   drops; no word is lost.
//   Reset clears all valid bits; no word is pending afterwards.
module quad_corner_metrics_unit
    import qcm_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = 13
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [17:0]  corner0_x,
    input  logic signed [17:0]  corner0_y,
    input  logic signed [17:0]  corner1_x,
    input  logic signed [17:0]  corner1_y,
    input  logic signed [17:0]  corner2_x,
    input  logic signed [17:0]  corner2_y,
    input  logic signed [17:0]  corner3_x,
    input  logic signed [17:0]  corner3_y,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [18:0]         mean_side,
    output logic [15:0]         squareness,
    output logic signed [15:0]  orientation,
    output logic                degenerate
);

    // Stages: input reg, product reg, cordic (1 + 1 + 31), merge A, merge B1, merge B2
    localparam int unsigned LAT = STEPS + 7;
    localparam int unsigned RS  = 30 - ANGLE_FRAC_BITS;

    logic       en;
    stage_ctl_t ctl_reg [LAT];

    assign en       = !out_valid || out_ready;
    assign in_ready = en;

    // Capture corners
    coord_t cx_reg [4];
    coord_t cy_reg [4];
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx_reg[0] <= corner0_x; cy_reg[0] <= corner0_y;
            cx_reg[1] <= corner1_x; cy_reg[1] <= corner1_y;
            cx_reg[2] <= corner2_x; cy_reg[2] <= corner2_y;
            cx_reg[3] <= corner3_x; cy_reg[3] <= corner3_y;
        end
    end

    // Edge vectors: e[i] = c[i+1] - c[i]
    edge_t ex [4];
    edge_t ey [4];
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            ex[i] = EDGE_W'(cx_reg[(i+1)%4]) - EDGE_W'(cx_reg[i]);
            ey[i] = EDGE_W'(cy_reg[(i+1)%4]) - EDGE_W'(cy_reg[i]);
        end
    end

    // Per-lane products: squared lengths, cross and dot at each corner
    logic [SQ_W-1:0]        s2_reg  [4];
    logic signed [PROD_W:0] cr_reg  [4];
    logic signed [PROD_W:0] dt_reg  [4];
    logic signed [PROD_W:0] ox_reg;
    logic signed [PROD_W:0] oy_reg;
    logic                   dg_next;

    always_comb
    begin
        dg_next = 1'b0;
        for (int i = 0; i < 4; i++)
        begin
            dg_next = dg_next | ((ex[i] == '0) && (ey[i] == '0));
        end
    end

    for (genvar i = 0; i < 4; i++)
    begin : g_prod
        localparam int P = (i + 3) % 4;
        edge_t ax, ay, bx, by;
        logic signed [PROD_W-1:0] axby, aybx, axbx, ayby;
        assign ax = -ex[P];
        assign ay = -ey[P];
        assign bx = ex[i];
        assign by = ey[i];
        assign axby = PROD_W'(ax * by);
        assign aybx = PROD_W'(ay * bx);
        assign axbx = PROD_W'(ax * bx);
        assign ayby = PROD_W'(ay * by);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                s2_reg[i] <= SQ_W'({ 2'b00,
                    PROD_W'(ex[i] * ex[i]) + PROD_W'(ey[i] * ey[i]) } << 4);
                cr_reg[i] <= (PROD_W+1)'(axby) - (PROD_W+1)'(aybx);
                dt_reg[i] <= (PROD_W+1)'(axbx) + (PROD_W+1)'(ayby);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= (PROD_W+1)'(cx_reg[1]) + (PROD_W+1)'(cx_reg[2])
                    - (PROD_W+1)'(cx_reg[0]) - (PROD_W+1)'(cx_reg[3]);
            oy_reg <= (PROD_W+1)'(cy_reg[1]) + (PROD_W+1)'(cy_reg[2])
                    - (PROD_W+1)'(cy_reg[0]) - (PROD_W+1)'(cy_reg[3]);
        end
    end

    // Control: valid and degenerate flag through the pipe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < LAT; k++)
            begin
                ctl_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            ctl_reg[0] <= '{valid: in_valid, degen: 1'b0};
            ctl_reg[1] <= '{valid: ctl_reg[0].valid, degen: dg_next};
            for (int k = 2; k < LAT; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Corner angle lanes
    logic signed [Z_W-1:0] ang [4];
    for (genvar i = 0; i < 4; i++)
    begin : g_ang
        logic signed [PROD_W:0] acr;
        assign acr = cr_reg[i][PROD_W] ? -cr_reg[i] : cr_reg[i];
        qcm_cordic u_cordic (
            .clk   (clk),
            .en    (en),
            .y_in  (acr),
            .x_in  (dt_reg[i]),
            .z_out (ang[i])
        );
    end

    // Orientation lane
    logic signed [Z_W-1:0] zo;
    qcm_cordic u_orient (
        .clk   (clk),
        .en    (en),
        .y_in  (oy_reg),
        .x_in  (ox_reg),
        .z_out (zo)
    );

    // Side length lanes, delayed to line up with the CORDIC output
    localparam int unsigned SQD = STEPS + 2 - (ROOT_W + 1);
    logic [ROOT_W:0] root [4];
    logic [ROOT_W:0] rd_reg [4][SQD];
    for (genvar i = 0; i < 4; i++)
    begin : g_side
        qcm_isqrt u_sqrt (
            .clk   (clk),
            .en    (en),
            .val   (s2_reg[i]),
            .root  (root[i])
        );
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rd_reg[i][0] <= root[i];
                for (int k = 1; k < SQD; k++)
                begin
                    rd_reg[i][k] <= rd_reg[i][k-1];
                end
            end
        end
    end

    // Merge A: max deviation, side sum, orientation rounding
    logic [Z_W-1:0]    dev [4];
    logic [Z_W-1:0]    maxdev;
    logic [ROOT_W+2:0] sum4;
    logic signed [Z_W:0] zr;
    always_comb
    begin
        maxdev = '0;
        sum4   = '0;
        for (int i = 0; i < 4; i++)
        begin
            dev[i] = (ang[i] >= HALF_PI_Q30) ? Z_W'(ang[i] - HALF_PI_Q30)
                                              : Z_W'(HALF_PI_Q30 - ang[i]);
            if (dev[i] > maxdev)
            begin
                maxdev = dev[i];
            end
            sum4 = sum4 + (ROOT_W+3)'(rd_reg[i][SQD-1]);
        end
        zr = ((Z_W+1)'(zo) + ((Z_W+1)'(1) << RS >>> 1)) >>> RS;
    end

    logic [Z_W-1:0]         maxdev_reg;
    logic [ROOT_W+2:0]      sum_reg;
    logic signed [Z_W:0]    zr_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            maxdev_reg <= maxdev;
            sum_reg    <= sum4 + (ROOT_W+3)'(8);
            zr_reg     <= zr;
        end
    end

    // Squareness scale constants: reciprocal of HALF_PI in Q32, HALF_PI and its multiples
    localparam logic [31:0]     SQ_RECIP  = 32'((64'd1 << 62) / 64'(HALF_PI_Q30));
    localparam logic [Z_W+15:0] HP_W      = (Z_W+16)'(HALF_PI_Q30);
    localparam logic [Z_W+15:0] HP2_W     = HP_W << 1;
    localparam logic [Z_W+15:0] HP_HALF_W = HP_W >> 1;

    // Merge B1: estimate maxdev * 32768 / HALF_PI by reciprocal multiply
    logic [Z_W+31:0]     rp_reg;
    logic [Z_W-1:0]      md_reg;
    logic [ROOT_W+2:0]   sum1_reg;
    logic signed [Z_W:0] zr1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rp_reg   <= (Z_W+32)'(maxdev_reg * SQ_RECIP);
            md_reg   <= maxdev_reg;
            sum1_reg <= sum_reg;
            zr1_reg  <= zr_reg;
        end
    end

    // Merge B2: take the quotient estimate, its product and the rounded numerator
    logic [16:0]         qe_next;
    logic [16:0]         qe_reg;
    logic [Z_W+15:0]     qh_reg;
    logic [Z_W+15:0]     num_reg;
    logic [ROOT_W+2:0]   sum2_reg;
    logic signed [Z_W:0] zr2_reg;
    assign qe_next = 17'(rp_reg >> 47);
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            qe_reg   <= qe_next;
            qh_reg   <= (Z_W+16)'(qe_next) * HP_W;
            num_reg  <= ((Z_W+16)'(md_reg) << 15) + HP_HALF_W;
            sum2_reg <= sum1_reg;
            zr2_reg  <= zr1_reg;
        end
    end

    // Correct the estimate by up to two from the remainder
    logic [Z_W+15:0] rem;
    logic [16:0]     q;
    logic signed [17:0] sq;
    logic [19:0]     mean;
    always_comb
    begin
        rem = num_reg - qh_reg;
        if (rem >= HP2_W)
            q = qe_reg + 17'd2;
        else if (rem >= HP_W)
            q = qe_reg + 17'd1;
        else
            q = qe_reg;
        sq   = 18'sd32768 - $signed({ 1'b0, q });
        mean = 20'(sum2_reg >> 4);
    end

    logic [18:0]         mean_reg;
    logic [15:0]         sq_reg;
    logic signed [15:0]  ang_reg;
    logic                dg_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mean_reg <= (mean > 20'd524287) ? 19'd524287 : mean[18:0];
            sq_reg   <= ctl_reg[LAT-1].degen ? 16'd0 :
                        (sq < 0) ? 16'd0 : sq[15:0];
            ang_reg  <= (zr2_reg > 32767) ? 16'sd32767 :
                        (zr2_reg < -32768) ? -16'sd32768 : zr2_reg[15:0];
            dg_reg   <= ctl_reg[LAT-1].degen;
        end
    end

    // Output register valid
    logic ov_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            ov_reg <= ctl_reg[LAT-1].valid;
        end
    end

    assign out_valid   = ov_reg;
    assign mean_side   = mean_reg;
    assign squareness  = sq_reg;
    assign orientation = ang_reg;
    assign degenerate  = dg_reg;

endmodule

// ----- test/tb_quad_corner_metrics_unit.sv -----
// Testbench for quad_corner_metrics_unit: drives quads through the valid/ready
// channels and checks every result word against a behavioral predictor.
// Depends on qcm_pkg and the quad_corner_metrics_unit RTL.
`timescale 1ns / 100ps

typedef struct {
    logic [18:0]        mean_side;
    logic [15:0]        squareness;
    logic signed [15:0] orientation;
    logic               degenerate;
} quad_metrics_t;

// Expected metrics, one entry per accepted quad, oldest first
class quad_metrics_board;
    quad_metrics_t pending[$];
    int            errors = 0;

    static function longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Vectoring atan2 in Q30 radians
    static function longint atan2_q30(longint y, longint x);
        longint z, t, xs, ys, m, ax, ay;
        int sh;
        longint tbl[31];
        tbl = '{843314857, 497837829, 263043837, 133525159, 67021687,
                33543516, 16775851, 8388437, 4194283, 2097149,
                1048576, 524288, 262144, 131072, 65536, 32768, 16384, 8192,
                4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1};
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        m = (ax > ay) ? ax : ay;
        sh = 0;
        while (m < (64'sd1 <<< 40))
        begin
            m = m <<< 1;
            sh++;
        end
        x = x <<< sh;
        y = y <<< sh;
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y; y = -t; z = 1686629713;
            end
            else
            begin
                t = x; x = -y; y = t; z = -1686629713;
            end
        end
        for (int i = 0; i < 31; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys; y = y - xs; z += tbl[i];
            end
            else
            begin
                x = x - ys; y = y + xs; z -= tbl[i];
            end
        end
        return z;
    endfunction

    // Integer square root rounded to nearest
    static function longint root_round(longint v);
        longint r, b, n;
        r = 0;
        b = 64'sd1 <<< 62;
        n = v;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n -= r + b;
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        if (v - r * r > r)
            r++;
        return r;
    endfunction

    // Note an accepted quad and compute its expected metrics
    function void note_quad(longint cx[4], longint cy[4]);
        quad_metrics_t e;
        longint sum4, mean, maxdev, sq, z, ang, dx, dy, s2, ax, ay, bx, by, cr, dt, a, d;
        logic degen;
        sum4 = 0;
        degen = 0;
        maxdev = 0;
        for (int i = 0; i < 4; i++)
        begin
            dx = cx[(i + 1) % 4] - cx[i];
            dy = cy[(i + 1) % 4] - cy[i];
            s2 = dx * dx + dy * dy;
            if (s2 == 0)
                degen = 1;
            sum4 += root_round(s2 <<< 4);
        end
        mean = (sum4 + 8) >>> 4;
        if (mean > 524287)
            mean = 524287;
        if (degen)
            sq = 0;
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                ax = cx[(i + 3) % 4] - cx[i]; ay = cy[(i + 3) % 4] - cy[i];
                bx = cx[(i + 1) % 4] - cx[i]; by = cy[(i + 1) % 4] - cy[i];
                cr = ax * by - ay * bx;
                dt = ax * bx + ay * by;
                a = atan2_q30(cr < 0 ? -cr : cr, dt);
                d = a - 1686629713;
                if (d < 0)
                    d = -d;
                if (d > maxdev)
                    maxdev = d;
            end
            sq = 32768 - (maxdev * 32768 + 1686629713 / 2) / 1686629713;
            if (sq < 0)
                sq = 0;
            if (sq > 32768)
                sq = 32768;
        end
        z = atan2_q30(cy[1] + cy[2] - cy[0] - cy[3], cx[1] + cx[2] - cx[0] - cx[3]);
        ang = floor_shift(z + (64'sd1 <<< 16), 17);
        if (ang > 32767)
            ang = 32767;
        if (ang < -32768)
            ang = -32768;
        e.mean_side = mean[18:0];
        e.squareness = sq[15:0];
        e.orientation = ang[15:0];
        e.degenerate = degen;
        pending.push_back(e);
    endfunction

    // Compare one result word with the oldest expectation
    function void check_result(quad_metrics_t got);
        quad_metrics_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result word mean_side=%0d", $time, got.mean_side);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (got.mean_side !== e.mean_side)
        begin
            $display("%0t: mean_side expected %0d actual %0d", $time, e.mean_side,
                     got.mean_side);
            errors++;
        end
        if (got.squareness !== e.squareness)
        begin
            $display("%0t: squareness expected %0d actual %0d", $time, e.squareness,
                     got.squareness);
            errors++;
        end
        if (got.orientation !== e.orientation)
        begin
            $display("%0t: orientation expected %0d actual %0d", $time, e.orientation,
                     got.orientation);
            errors++;
        end
        if (got.degenerate !== e.degenerate)
        begin
            $display("%0t: degenerate expected %0d actual %0d", $time, e.degenerate,
                     got.degenerate);
            errors++;
        end
    endfunction
endclass

module tb_quad_corner_metrics_unit;
    import qcm_pkg::*;

    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    coord_t c0x = 0, c0y = 0, c1x = 0, c1y = 0, c2x = 0, c2y = 0, c3x = 0, c3y = 0;
    logic out_valid;
    logic out_ready = 0;
    logic [18:0] mean_side;
    logic [15:0] squareness;
    logic signed [15:0] orientation;
    logic degenerate;

    quad_metrics_board board = new();
    bit sending_done = 0;
    bit hold_off = 0;

    quad_corner_metrics_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .corner0_x(c0x), .corner0_y(c0y), .corner1_x(c1x), .corner1_y(c1y),
        .corner2_x(c2x), .corner2_y(c2y), .corner3_x(c3x), .corner3_y(c3y),
        .out_valid(out_valid), .out_ready(out_ready),
        .mean_side(mean_side), .squareness(squareness),
        .orientation(orientation), .degenerate(degenerate)
    );

    always #5 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one quad and hold it until accepted
    task automatic send_quad(coord_t q[8]);
        longint cx[4], cy[4];
        c0x <= q[0]; c0y <= q[1]; c1x <= q[2]; c1y <= q[3];
        c2x <= q[4]; c2y <= q[5]; c3x <= q[6]; c3y <= q[7];
        in_valid <= 1;
        do
            @(posedge clk);
        while (!in_ready);
        for (int i = 0; i < 4; i++)
        begin
            cx[i] = q[2 * i];
            cy[i] = q[2 * i + 1];
        end
        board.note_quad(cx, cy);
        @(negedge clk);
    endtask

    task automatic idle_in(int n);
        if (n > 0)
        begin
            in_valid <= 0;
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic coord_t rnd_coord();
        case ($urandom_range(0, 3))
            0: return coord_t'($urandom);
            1: return $urandom_range(0, 1) ? 18'sh1ffff : 18'sh20000;
            default: return coord_t'($urandom_range(0, 4000)) - 18'sd2000;
        endcase
    endfunction

    // Mostly near-square quads with random center, size and rotation
    function automatic void make_quad(output coord_t q[8]);
        int kind, cxn, cyn, vx, vy, jit;
        kind = $urandom_range(0, 9);
        if (kind < 7)
        begin
            jit = $urandom_range(0, 3) == 0 ? 200 : 4;
            cxn = $urandom_range(0, 100000) - 50000;
            cyn = $urandom_range(0, 100000) - 50000;
            vx = $urandom_range(0, (kind < 5) ? 2000 : 60000) - ((kind < 5) ? 1000 : 30000);
            vy = $urandom_range(0, (kind < 5) ? 2000 : 60000) - ((kind < 5) ? 1000 : 30000);
            q[0] = coord_t'(cxn + vx + $urandom_range(0, jit) - jit / 2);
            q[1] = coord_t'(cyn + vy + $urandom_range(0, jit) - jit / 2);
            q[2] = coord_t'(cxn - vy + $urandom_range(0, jit) - jit / 2);
            q[3] = coord_t'(cyn + vx + $urandom_range(0, jit) - jit / 2);
            q[4] = coord_t'(cxn - vx + $urandom_range(0, jit) - jit / 2);
            q[5] = coord_t'(cyn - vy + $urandom_range(0, jit) - jit / 2);
            q[6] = coord_t'(cxn + vy + $urandom_range(0, jit) - jit / 2);
            q[7] = coord_t'(cyn - vx + $urandom_range(0, jit) - jit / 2);
        end
        else
            for (int i = 0; i < 8; i++)
                q[i] = rnd_coord();
        // Occasionally collapse a side
        if ($urandom_range(0, 19) == 0)
        begin
            int k;
            k = $urandom_range(0, 3);
            q[2 * ((k + 1) % 4)] = q[2 * k];
            q[2 * ((k + 1) % 4) + 1] = q[2 * k + 1];
        end
    endfunction

    // Stimulus
    initial
    begin
        coord_t q[8];
        coord_t dir[12][8];
        dir = '{
            '{0, 0, 16, 0, 16, 16, 0, 16},
            '{0, 0, 0, 0, 0, 0, 0, 0},
            '{-131072, -131072, 131071, -131072, 131071, 131071, -131072, 131071},
            '{131071, 131071, -131072, 131071, -131072, -131072, 131071, -131072},
            '{-131072, 131071, 131071, -131072, -131072, 131071, 131071, -131072},
            '{0, 0, 0, 0, 100, 100, 100, 100},
            '{0, 100, 0, 0, 0, 0, 0, 100},
            '{0, 0, 0, 0, 0, 0, 5, 0},
            '{10, 0, 0, 10, -10, 0, 0, -10},
            '{0, 0, 50, 3, 100, 0, 50, -3},
            '{-1, -1, 1, -1, 1, 1, -1, 1},
            '{-131072, 0, 131071, 0, 131071, 0, -131072, 0}
        };
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        foreach (dir[i])
        begin
            q = dir[i];
            send_quad(q);
            idle_in(gap_len());
        end
        for (int i = 0; i < 1540; i++)
        begin
            if (i == 500)
                hold_off = 1;
            make_quad(q);
            send_quad(q);
            idle_in((i > 1300) ? 0 : gap_len());
        end
        in_valid <= 0;
        sending_done = 1;
    end

    // Receiver: random stalls plus one long hold-off
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                hold_off = 0;
                out_ready <= 0;
                repeat (200) @(negedge clk);
            end
            n = gap_len();
            if (n > 0 && $urandom_range(0, 1))
            begin
                out_ready <= 0;
                repeat (n) @(negedge clk);
            end
            out_ready <= 1;
        end
    end

    // Sample results at the rising edge
    always @(posedge clk)
    begin
        quad_metrics_t got;
        if (rst_n && out_valid && out_ready)
        begin
            got.mean_side = mean_side;
            got.squareness = squareness;
            got.orientation = orientation;
            got.degenerate = degenerate;
            board.check_result(got);
        end
    end

    // End of run
    initial
    begin
        wait (sending_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (board.errors == 0)
            $display("quad_corner_metrics_unit: match");
        else
            $display("quad_corner_metrics_unit: mismatch");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("quad_corner_metrics_unit: mismatch");
        $finish;
    end
endmodule
